// ===== hdl/lru_tag_cache_lookup_core_macros.svh =====
// ----------------------------------------------------------------------------
// LRU tag cache lookup core macros
// Assertion shorthands used by the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef LRU_TAG_CACHE_LOOKUP_CORE_MACROS_SVH
`define LRU_TAG_CACHE_LOOKUP_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define LTC_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ltc port check failed");

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define LTC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ltc port check failed");

`endif

// ===== hdl/ltc_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU tag cache lookup package
// Shared widths, codes, entry layout and controller/datapath interface types.
// ----------------------------------------------------------------------------
package ltc_pkg;

    localparam int LTC_SLOTS    = 64;
    localparam int KEY_W        = 16;
    localparam int STAMP_W      = 32;
    localparam int TOTAL_W      = 32;
    localparam int FILL_W       = 7;
    localparam int SLOT_OUT_W   = 6;
    localparam int IN_DATA_W    = 2 * KEY_W;
    localparam int OUT_FIELDS_W = SLOT_OUT_W + 3 * TOTAL_W + FILL_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

    localparam logic [STAMP_W-1:0] STAMP_MAX = 32'hFFFF_FFFF;
    localparam logic [FILL_W-1:0]  FILL_MAX  = 7'd127;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef enum logic [1:0] {
        OUT_HIT     = 2'd0,
        OUT_FILL    = 2'd1,
        OUT_EVICT   = 2'd2,
        OUT_CLEARED = 2'd3
    } outcome_t;

    typedef struct packed {
        logic [KEY_W-1:0]   char_code;
        logic [KEY_W-1:0]   glyph_size;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;       // input beat taken: latch key, restart scan
        logic scan;        // issue reads and judge returned entries
        logic update;      // write target entry, bump counters, load result
        logic wipe;        // write one empty entry at the sweep address
        logic emit_clear;  // reset clock and occupancy, load cleared result
    } ltc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;         // entry under judgment matches the key
        logic scan_done;   // last entry judged
        logic wipe_last;   // sweep is writing its last entry
        logic out_free;    // result register can take a new result
    } ltc_status_t;

endpackage

// ===== hdl/ltc_ctrl.sv =====
// ----------------------------------------------------------------------------
// LRU tag cache lookup controller
// Sequences the clearing sweep, the slot scan, the entry update and results.
// ----------------------------------------------------------------------------
module ltc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                s_tuser,
    output ltc_pkg::ltc_cmd_t   cmd,
    input  ltc_pkg::ltc_status_t status
);
    import ltc_pkg::*;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_WIPE,
        ST_CLEARED
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.wipe = 1'b1;
                if (status.wipe_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.start  = 1'b1;
                    state_next = (s_tuser == CMD_CLEAR) ? ST_WIPE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.hit || status.scan_done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (status.out_free)
                begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_WIPE:
            begin
                cmd.wipe = 1'b1;
                if (status.wipe_last)
                begin
                    state_next = ST_CLEARED;
                end
            end
            ST_CLEARED:
            begin
                if (status.out_free)
                begin
                    cmd.emit_clear = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/ltc_datapath.sv =====
// ----------------------------------------------------------------------------
// LRU tag cache lookup datapath
// Entry memory, scan judgment, replacement choice, counters and result register.
// ----------------------------------------------------------------------------
module ltc_datapath #(
    parameter int SLOTS = ltc_pkg::LTC_SLOTS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ltc_pkg::ltc_cmd_t                 cmd,
    output ltc_pkg::ltc_status_t              status,
    input  logic [ltc_pkg::KEY_W-1:0]         char_code,
    input  logic [ltc_pkg::KEY_W-1:0]         glyph_size,
    output logic                              out_valid,
    input  logic                              out_ready,
    output ltc_pkg::outcome_t                 outcome,
    output logic [ltc_pkg::SLOT_OUT_W-1:0]    slot_index,
    output logic [ltc_pkg::TOTAL_W-1:0]       hit_total,
    output logic [ltc_pkg::TOTAL_W-1:0]       miss_total,
    output logic [ltc_pkg::TOTAL_W-1:0]       eviction_total,
    output logic [ltc_pkg::FILL_W-1:0]        occupied_total
);
    import ltc_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W:0]   CNT_END  = (IDX_W+1)'(SLOTS);
    localparam logic [IDX_W:0]   CNT_LAST = (IDX_W+1)'(SLOTS - 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

    entry_t mem [SLOTS];

    // Key under lookup.
    logic [KEY_W-1:0]   key_char_reg;
    logic [KEY_W-1:0]   key_size_reg;

    // Scan and sweep address counter; one bit wider so it can mark the end.
    logic [IDX_W:0]     cnt_reg;
    logic               rd_vld_reg;
    logic [IDX_W-1:0]   eval_idx_reg;
    entry_t             rd_entry_reg;

    // Scan findings.
    logic               hit_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic               have_empty_reg;
    logic [IDX_W-1:0]   first_empty_reg;
    logic [IDX_W-1:0]   victim_reg;
    logic [STAMP_W-1:0] victim_stamp_reg;

    // Persistent state.
    logic [STAMP_W-1:0] stamp_clock_reg;
    logic [TOTAL_W-1:0] hit_cnt_reg;
    logic [TOTAL_W-1:0] miss_cnt_reg;
    logic [TOTAL_W-1:0] evict_cnt_reg;
    logic [FILL_W-1:0]  fill_cnt_reg;

    // Result register.
    logic               out_valid_reg;
    outcome_t           outcome_reg;
    logic [SLOT_OUT_W-1:0] slot_reg;
    logic [TOTAL_W-1:0] hit_out_reg;
    logic [TOTAL_W-1:0] miss_out_reg;
    logic [TOTAL_W-1:0] evict_out_reg;
    logic [FILL_W-1:0]  fill_out_reg;

    logic               issue;
    logic               judge;
    logic               entry_empty;
    logic               entry_match;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    entry_t             mem_wdata;
    logic [IDX_W-1:0]   target;
    outcome_t           upd_outcome;
    logic [TOTAL_W-1:0] hit_cnt_next;
    logic [TOTAL_W-1:0] miss_cnt_next;
    logic [TOTAL_W-1:0] evict_cnt_next;
    logic [FILL_W-1:0]  fill_cnt_next;

    assign issue       = cmd.scan && (cnt_reg < CNT_END);
    assign judge       = cmd.scan && rd_vld_reg;
    assign entry_empty = (rd_entry_reg.char_code == '0);
    assign entry_match = !entry_empty && (rd_entry_reg.char_code == key_char_reg)
                         && (rd_entry_reg.glyph_size == key_size_reg);

    assign status.hit       = judge && entry_match;
    assign status.scan_done = judge && (eval_idx_reg == IDX_LAST);
    assign status.wipe_last = cmd.wipe && (cnt_reg == CNT_LAST);
    assign status.out_free  = !out_valid_reg || out_ready;

    // Replacement choice and counter updates for the end of a lookup.
    always_comb
    begin
        hit_cnt_next   = hit_cnt_reg;
        miss_cnt_next  = miss_cnt_reg;
        evict_cnt_next = evict_cnt_reg;
        fill_cnt_next  = fill_cnt_reg;
        if (hit_reg)
        begin
            target        = hit_idx_reg;
            upd_outcome   = OUT_HIT;
            hit_cnt_next  = hit_cnt_reg + 1'b1;
        end
        else if (have_empty_reg)
        begin
            target        = first_empty_reg;
            upd_outcome   = OUT_FILL;
            miss_cnt_next = miss_cnt_reg + 1'b1;
            if (fill_cnt_reg != FILL_MAX)
            begin
                fill_cnt_next = fill_cnt_reg + 1'b1;
            end
        end
        else
        begin
            target         = victim_reg;
            upd_outcome    = OUT_EVICT;
            miss_cnt_next  = miss_cnt_reg + 1'b1;
            evict_cnt_next = evict_cnt_reg + 1'b1;
        end
    end

    // Single write port: the clearing sweep or the end-of-lookup update.
    always_comb
    begin
        mem_we    = cmd.wipe || cmd.update;
        mem_waddr = cmd.wipe ? cnt_reg[IDX_W-1:0] : target;
        mem_wdata = '0;
        if (cmd.update)
        begin
            mem_wdata.char_code  = key_char_reg;
            mem_wdata.glyph_size = key_size_reg;
            mem_wdata.stamp      = stamp_clock_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (issue)
        begin
            rd_entry_reg <= mem[cnt_reg[IDX_W-1:0]];
            eval_idx_reg <= cnt_reg[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg          <= '0;
            rd_vld_reg       <= 1'b0;
            hit_reg          <= 1'b0;
            have_empty_reg   <= 1'b0;
            stamp_clock_reg  <= STAMP_W'(1);
            hit_cnt_reg      <= '0;
            miss_cnt_reg     <= '0;
            evict_cnt_reg    <= '0;
            fill_cnt_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= issue;

            if (cmd.start)
            begin
                cnt_reg        <= '0;
                hit_reg        <= 1'b0;
                have_empty_reg <= 1'b0;
            end
            else if (issue || cmd.wipe)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end

            if (judge)
            begin
                if (entry_empty)
                begin
                    have_empty_reg <= 1'b1;
                end
                else if (entry_match)
                begin
                    hit_reg <= 1'b1;
                end
            end

            if (cmd.update)
            begin
                stamp_clock_reg <= stamp_clock_reg + 1'b1;
                hit_cnt_reg     <= hit_cnt_next;
                miss_cnt_reg    <= miss_cnt_next;
                evict_cnt_reg   <= evict_cnt_next;
                fill_cnt_reg    <= fill_cnt_next;
            end
            else if (cmd.emit_clear)
            begin
                stamp_clock_reg <= STAMP_W'(1);
                fill_cnt_reg    <= '0;
            end

            if (cmd.update || cmd.emit_clear)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers of the scan and the result need no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            key_char_reg     <= char_code;
            key_size_reg     <= glyph_size;
            victim_reg       <= '0;
            victim_stamp_reg <= STAMP_MAX;
        end
        else if (judge)
        begin
            if (entry_empty)
            begin
                if (!have_empty_reg)
                begin
                    first_empty_reg <= eval_idx_reg;
                end
            end
            else if (entry_match)
            begin
                hit_idx_reg <= eval_idx_reg;
            end
            else if (rd_entry_reg.stamp < victim_stamp_reg)
            begin
                // Strict compare keeps the lowest index among equal stamps.
                victim_stamp_reg <= rd_entry_reg.stamp;
                victim_reg       <= eval_idx_reg;
            end
        end

        if (cmd.update)
        begin
            outcome_reg   <= upd_outcome;
            slot_reg      <= SLOT_OUT_W'(target);
            hit_out_reg   <= hit_cnt_next;
            miss_out_reg  <= miss_cnt_next;
            evict_out_reg <= evict_cnt_next;
            fill_out_reg  <= fill_cnt_next;
        end
        else if (cmd.emit_clear)
        begin
            outcome_reg   <= OUT_CLEARED;
            slot_reg      <= '0;
            hit_out_reg   <= hit_cnt_reg;
            miss_out_reg  <= miss_cnt_reg;
            evict_out_reg <= evict_cnt_reg;
            fill_out_reg  <= '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign outcome        = outcome_reg;
    assign slot_index     = slot_reg;
    assign hit_total      = hit_out_reg;
    assign miss_total     = miss_out_reg;
    assign eviction_total = evict_out_reg;
    assign occupied_total = fill_out_reg;

endmodule

// ===== hdl/lru_tag_cache_lookup_core.sv =====
// ----------------------------------------------------------------------------
// LRU tag cache lookup core
// Fully associative key store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each input beat either looks up a (char_code, glyph_size) key or clears the
// store, and yields exactly one result beat. The entries live in a memory of
// SLOTS words, written through a single port and scanned one slot per cycle
// from slot 0 upward, so the scan of that memory sets the rate: a lookup that
// hits ends its scan at the hitting slot, a miss scans every slot, and a clear
// sweeps every slot empty; the final step of each waits while an earlier
// result still waits on the output. After reset a clearing pass sweeps every
// slot empty before the first beat is taken. One item is in flight at a time;
// a new beat is taken while the previous result still waits on the output.
module lru_tag_cache_lookup_core #(
    parameter int SLOTS = ltc_pkg::LTC_SLOTS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata, from bit 0: char_code[15:0], glyph_size[15:0]
    input  logic [ltc_pkg::IN_DATA_W-1:0]     s_tdata,
    // s_tuser: cmd (0 lookup, 1 clear)
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata, from bit 0: slot_index[5:0], hit_total[31:0], miss_total[31:0],
    // eviction_total[31:0], occupied_total[6:0], zero padding
    output logic [ltc_pkg::OUT_DATA_W-1:0]    m_tdata,
    // m_tuser: outcome[1:0]
    output logic [1:0]                        m_tuser
);
    import ltc_pkg::*;

    ltc_cmd_t               cmd;
    ltc_status_t            status;
    outcome_t               outcome;
    logic [SLOT_OUT_W-1:0]  slot_index;
    logic [TOTAL_W-1:0]     hit_total;
    logic [TOTAL_W-1:0]     miss_total;
    logic [TOTAL_W-1:0]     eviction_total;
    logic [FILL_W-1:0]      occupied_total;

    ltc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .status   (status)
    );

    ltc_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .char_code      (s_tdata[KEY_W-1:0]),
        .glyph_size     (s_tdata[2*KEY_W-1:KEY_W]),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .outcome        (outcome),
        .slot_index     (slot_index),
        .hit_total      (hit_total),
        .miss_total     (miss_total),
        .eviction_total (eviction_total),
        .occupied_total (occupied_total)
    );

    assign m_tdata = {{OUT_PAD_W{1'b0}}, occupied_total, eviction_total,
                      miss_total, hit_total, slot_index};
    assign m_tuser = outcome;

endmodule

// ===== hdl/ltc_checker.sv =====
// ----------------------------------------------------------------------------
// LRU tag cache lookup port checker
// Watches the top-level ports over time; bound to the core below.
// ----------------------------------------------------------------------------
`include "lru_tag_cache_lookup_core_macros.svh"

module ltc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [ltc_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [1:0]                     m_tuser
);
    import ltc_pkg::*;

    logic [SLOT_OUT_W-1:0] out_slot;
    logic [FILL_W-1:0]     out_occ;
    logic                  out_clear;

    assign out_slot  = m_tdata[SLOT_OUT_W-1:0];
    assign out_occ   = m_tdata[SLOT_OUT_W + 3*TOTAL_W +: FILL_W];
    assign out_clear = m_tvalid && (m_tuser == OUT_CLEARED);

    // A stalled result beat holds.
    `LTC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable({m_tuser, m_tdata}))

    // Only one item is worked on at a time, so the input closes after a beat.
    `LTC_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)

    // A cleared result reports slot zero and an empty store.
    `LTC_ASSERT_IMPLY(a_clear_result, out_clear, (out_slot == '0) && (out_occ == '0))

    // A hit needs an entry filled since the last clear.
    `LTC_ASSERT_IMPLY(a_hit_occupied, m_tvalid && (m_tuser == OUT_HIT), out_occ != '0)

endmodule

bind lru_tag_cache_lookup_core ltc_checker u_ltc_checker (.*);
